>>> sv/der_common_name_scanner_unit_macros.svh
// assertion helpers for the dncs checker
`ifndef DER_COMMON_NAME_SCANNER_UNIT_MACROS_SVH
`define DER_COMMON_NAME_SCANNER_UNIT_MACROS_SVH

// same-cycle implication, clocked on clock, quiet during reset
`define DNCS_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dncs check failed");

// next-cycle implication
`define DNCS_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dncs check failed");

`endif

>>> sv/dncs_pkg.sv
`timescale 1ns / 1ps

package dncs_pkg;

   localparam int CapWidth  = 9;
   localparam int CharWidth = 16;

   localparam logic [7:0] TagUtf8      = 8'h0C;
   localparam logic [7:0] TagPrintable = 8'h13;
   localparam logic [7:0] TagIa5       = 8'h16;
   localparam logic [7:0] TagT61       = 8'h14;
   localparam logic [7:0] TagBmp       = 8'h1E;

   localparam logic [7:0] OidFirst     = 8'h06;
   localparam logic [7:0] PrintLow     = 8'h20;
   localparam logic [7:0] PrintHigh    = 8'h7E;
   localparam logic [7:0] Substitute   = 8'h3F;

   localparam logic [2:0] PatternLen   = 3'd5;

   typedef struct packed {
      logic [CapWidth-1:0] first_capacity;
      logic [CapWidth-1:0] second_capacity;
   } cap_type;

   typedef struct packed {
      logic                 which_name;
      logic                 char_valid;
      logic [CharWidth-1:0] char_value;
      logic                 name_end;
      logic                 name_cut;
      logic                 scan_done;
      logic [1:0]           names_found;
   } rsp_payload_type;

   // commonName attribute: 06 03 55 04 03
   function automatic logic [7:0] pattern_byte(input logic [2:0] idx);
      logic [7:0] b;
      unique case (idx)
         3'd0:    b = 8'h06;
         3'd1:    b = 8'h03;
         3'd2:    b = 8'h55;
         3'd3:    b = 8'h04;
         3'd4:    b = 8'h03;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic tag_ok(input logic [7:0] t);
      return (t == TagUtf8) || (t == TagPrintable) || (t == TagIa5) ||
             (t == TagT61) || (t == TagBmp);
   endfunction

endpackage

>>> sv/dncs_if.sv
`timescale 1ns / 1ps

interface dncs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dncs_rsp_if;
   logic        valid;
   logic        ready;
   logic        which_name;
   logic        char_valid;
   logic [15:0] char_value;
   logic        name_end;
   logic        name_cut;
   logic        scan_done;
   logic [1:0]  names_found;

   modport source (output valid, output which_name, output char_valid, output char_value,
                   output name_end, output name_cut, output scan_done, output names_found,
                   input ready);
   modport sink (input valid, input which_name, input char_valid, input char_value,
                 input name_end, input name_cut, input scan_done, input names_found,
                 output ready);
endinterface

>>> sv/der_common_name_scanner_unit.sv
`timescale 1ns / 1ps

// commonName scanner for a DER certificate byte stream.
// req_chan takes one stream byte per transfer, with last_byte on the final
// byte. rsp_chan gives at most one result per byte: a kept character of
// the current name, the end of a name, or the final count on the last byte.
// Bytes that cause none of these give no transfer.
// A byte is registered in the input register, the scanner works on it there,
// and its result is registered in the result register that drives rsp valid.
// Throughput is one byte per cycle while no result waits on a low rsp ready;
// the whole step is a single pass of matcher, tag and length checks and the
// character converter.
// When rsp ready is low with a result held, a byte that yields no result
// still moves on, a byte that yields one waits in the input register, and
// req ready drops once that register is occupied.
// Reset clears the scanner and both pipeline stages and sets both capacities
// to 128. The APB registers sit at byte address 0 (first capacity) and 4
// (second capacity); write them only while the scanner is idle.

module der_common_name_scanner_unit (
   input  logic         clock,
   input  logic         reset,
   dncs_req_if.sink     req_chan,
   dncs_rsp_if.source   rsp_chan,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   dncs_pkg::cap_type         caps;
   dncs_pkg::rsp_payload_type rsp_data;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       step_ready;
   logic       req_take;

   dncs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .caps    (caps)
   );

   assign req_chan.ready = !in_valid_ff || step_ready;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step_ready) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_byte_ff <= req_chan.data_byte;
         in_last_ff <= req_chan.last_byte;
      end
   end

   dncs_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step_valid (in_valid_ff),
      .step_ready (step_ready),
      .step_byte  (in_byte_ff),
      .step_last  (in_last_ff),
      .caps       (caps),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .rsp_data   (rsp_data)
   );

   assign rsp_chan.which_name  = rsp_data.which_name;
   assign rsp_chan.char_valid  = rsp_data.char_valid;
   assign rsp_chan.char_value  = rsp_data.char_value;
   assign rsp_chan.name_end    = rsp_data.name_end;
   assign rsp_chan.name_cut    = rsp_data.name_cut;
   assign rsp_chan.scan_done   = rsp_data.scan_done;
   assign rsp_chan.names_found = rsp_data.names_found;

endmodule

>>> sv/dncs_csr.sv
`timescale 1ns / 1ps

module dncs_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output dncs_pkg::cap_type caps
);

   localparam logic [dncs_pkg::CapWidth-1:0] CapReset = 9'd128;

   logic [dncs_pkg::CapWidth-1:0] first_ff;
   logic [dncs_pkg::CapWidth-1:0] second_ff;
   logic                          wr_en;

   // bit 2 of the byte address picks the register
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign prdata = paddr[2] ? {23'd0, second_ff} : {23'd0, first_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= CapReset;
         second_ff <= CapReset;
      end else if (wr_en) begin
         if (paddr[2]) begin
            second_ff <= pwdata[dncs_pkg::CapWidth-1:0];
         end else begin
            first_ff <= pwdata[dncs_pkg::CapWidth-1:0];
         end
      end
   end

   assign caps.first_capacity  = first_ff;
   assign caps.second_capacity = second_ff;

endmodule

>>> sv/dncs_core.sv
`timescale 1ns / 1ps

module dncs_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_valid,
   output logic                     step_ready,
   input  logic [7:0]               step_byte,
   input  logic                     step_last,
   input  dncs_pkg::cap_type        caps,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output dncs_pkg::rsp_payload_type rsp_data
);

   typedef enum logic [1:0] {PH_SEARCH, PH_TAG, PH_LEN, PH_VALUE} phase_type;

   phase_type  phase_ff, phase_in;
   logic [2:0] match_ff, match_in;
   logic       bmp_ff, bmp_in;
   logic [6:0] left_ff, left_in;
   logic [1:0] found_ff, found_in;
   logic [6:0] chars_ff, chars_in;
   logic [7:0] high_ff, high_in;
   logic       odd_ff, odd_in;
   logic       stopped_ff, stopped_in;
   logic       rsp_valid_ff, rsp_valid_in;
   dncs_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic                          emit;
   logic                          produce;
   logic                          fire;
   logic                          out_free;
   logic                          have;
   logic [15:0]                   ch_val;
   logic [dncs_pkg::CapWidth-1:0] cap;
   logic [2:0]                    match_up;

   always_comb begin
      phase_in   = phase_ff;
      match_in   = match_ff;
      bmp_in     = bmp_ff;
      left_in    = left_ff;
      found_in   = found_ff;
      chars_in   = chars_ff;
      high_in    = high_ff;
      odd_in     = odd_ff;
      stopped_in = stopped_ff;
      emit       = 1'b0;
      have       = 1'b0;
      ch_val     = 16'd0;
      match_up   = 3'd0;
      cap        = (found_ff == 2'd0) ? caps.first_capacity : caps.second_capacity;
      rsp_in     = '0;

      if (!stopped_ff) begin
         unique case (phase_ff)
            PH_SEARCH: begin
               if (step_byte == dncs_pkg::pattern_byte(match_ff)) begin
                  match_up = match_ff + 3'd1;
               end else begin
                  match_up = (step_byte == dncs_pkg::OidFirst) ? 3'd1 : 3'd0;
               end
               if (match_up == dncs_pkg::PatternLen) begin
                  match_in = 3'd0;
                  phase_in = PH_TAG;
               end else begin
                  match_in = match_up;
               end
            end
            PH_TAG: begin
               if (dncs_pkg::tag_ok(step_byte)) begin
                  bmp_in   = (step_byte == dncs_pkg::TagBmp);
                  phase_in = PH_LEN;
               end else begin
                  // a rejected tag byte may open the next pattern
                  phase_in = PH_SEARCH;
                  match_in = (step_byte == dncs_pkg::OidFirst) ? 3'd1 : 3'd0;
               end
            end
            PH_LEN: begin
               if (step_byte == 8'd0 || step_byte[7]) begin
                  phase_in = PH_SEARCH;
                  match_in = 3'd0;
               end else begin
                  left_in  = step_byte[6:0];
                  chars_in = 7'd0;
                  odd_in   = 1'b0;
                  high_in  = 8'd0;
                  phase_in = PH_VALUE;
               end
            end
            PH_VALUE: begin
               if (bmp_ff) begin
                  if (odd_ff) begin
                     ch_val = {high_ff, step_byte};
                     have   = 1'b1;
                     odd_in = 1'b0;
                  end else begin
                     high_in = step_byte;
                     odd_in  = 1'b1;
                  end
               end else begin
                  have   = 1'b1;
                  ch_val = (step_byte >= dncs_pkg::PrintLow && step_byte <= dncs_pkg::PrintHigh)
                           ? {8'd0, step_byte} : {8'd0, dncs_pkg::Substitute};
               end
               if (have && cap != '0 && {2'b00, chars_ff} < (cap - 9'd1)) begin
                  rsp_in.char_valid = 1'b1;
                  rsp_in.char_value = ch_val;
                  rsp_in.which_name = found_ff[0];
                  chars_in          = chars_ff + 7'd1;
                  emit              = 1'b1;
               end
               left_in = left_ff - 7'd1;
               if (left_ff == 7'd1) begin
                  rsp_in.which_name = found_ff[0];
                  rsp_in.name_end   = 1'b1;
                  emit              = 1'b1;
                  found_in          = found_ff + 2'd1;
                  phase_in          = PH_SEARCH;
                  match_in          = 3'd0;
                  if (found_ff == 2'd1) begin
                     stopped_in = 1'b1;
                  end
               end
            end
            default: begin
               phase_in = PH_SEARCH;
            end
         endcase

         // stream ended inside a value: name is cut, scanning stops
         if (step_last && phase_in == PH_VALUE) begin
            rsp_in.name_cut   = 1'b1;
            rsp_in.which_name = found_ff[0];
            stopped_in        = 1'b1;
         end
      end

      rsp_in.scan_done   = step_last;
      rsp_in.names_found = found_in;

      // the last byte returns the scanner to its reset state
      if (step_last) begin
         phase_in   = PH_SEARCH;
         match_in   = 3'd0;
         bmp_in     = 1'b0;
         left_in    = 7'd0;
         found_in   = 2'd0;
         chars_in   = 7'd0;
         high_in    = 8'd0;
         odd_in     = 1'b0;
         stopped_in = 1'b0;
      end
   end

   assign produce    = emit || step_last;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign step_ready = out_free || !produce;
   assign fire       = step_valid && step_ready;

   always_comb begin
      if (fire && produce) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SEARCH;
         match_ff     <= 3'd0;
         bmp_ff       <= 1'b0;
         left_ff      <= 7'd0;
         found_ff     <= 2'd0;
         chars_ff     <= 7'd0;
         high_ff      <= 8'd0;
         odd_ff       <= 1'b0;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            phase_ff   <= phase_in;
            match_ff   <= match_in;
            bmp_ff     <= bmp_in;
            left_ff    <= left_in;
            found_ff   <= found_in;
            chars_ff   <= chars_in;
            high_ff    <= high_in;
            odd_ff     <= odd_in;
            stopped_ff <= stopped_in;
         end
      end
      if (fire && produce) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> sv/dncs_checker.sv
`timescale 1ns / 1ps
`include "der_common_name_scanner_unit_macros.svh"

module dncs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_char_valid,
   input logic [15:0] rsp_char_value,
   input logic        rsp_name_end,
   input logic        rsp_name_cut,
   input logic        rsp_scan_done
);

   // a stalled result stays put
   `DNCS_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_char_value))

   // a cut name never completes in the same transfer
   `DNCS_ASSERT_IMP(a_cut_not_end, rsp_valid && rsp_name_cut, !rsp_name_end)

   // a cut is only reported on the last byte
   `DNCS_ASSERT_IMP(a_cut_at_last, rsp_valid && rsp_name_cut, rsp_scan_done)

   // no character means a zero character field
   `DNCS_ASSERT_IMP(a_char_zero, rsp_valid && !rsp_char_valid, rsp_char_value == 16'd0)

endmodule

bind der_common_name_scanner_unit dncs_checker u_dncs_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_char_valid (rsp_chan.char_valid),
   .rsp_char_value (rsp_chan.char_value),
   .rsp_name_end   (rsp_chan.name_end),
   .rsp_name_cut   (rsp_chan.name_cut),
   .rsp_scan_done  (rsp_chan.scan_done)
);

>>> tb/der_common_name_scanner_unit_checker.sv
`timescale 1ns / 1ps

module der_common_name_scanner_unit_checker (
   input  logic        clock,
   input  logic        reset,
   dncs_req_if         req_mon,
   dncs_rsp_if         rsp_mon,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic [31:0] prdata,
   input  logic        pready,
   input  logic [2:0]  first_cap_addr,
   input  logic [2:0]  second_cap_addr,
   output int          mismatch_count,
   output int          pending_results
);

   typedef enum logic [1:0] {
      Searching,
      AwaitTag,
      AwaitLength,
      InValue
   } scan_phase_type;

   // 06 03 55 04 03, first byte in the top bits
   localparam logic [39:0] CnOid = 40'h06_03_55_04_03;

   logic [8:0]                first_cap;
   logic [8:0]                second_cap;
   logic [2:0]                oid_matched;
   scan_phase_type            phase;
   logic [7:0]                string_tag;
   logic [6:0]                bytes_left;
   logic [1:0]                names_count;
   logic [8:0]                kept_chars;
   logic [7:0]                bmp_high;
   logic                      bmp_pending;
   logic                      halted;
   dncs_pkg::rsp_payload_type name_events_due[$];
   int                        errors = 0;

   assign mismatch_count = errors;

   task automatic restart_scan();
      oid_matched = '0;
      phase       = Searching;
      string_tag  = '0;
      bytes_left  = '0;
      names_count = '0;
      kept_chars  = '0;
      bmp_high    = '0;
      bmp_pending = 1'b0;
      halted      = 1'b0;
   endtask

   task automatic scan_byte(input logic [7:0] b, input logic is_last,
                            output logic emit, output dncs_pkg::rsp_payload_type ev);
      logic [8:0]  cap;
      logic [15:0] char_code;
      logic        got_char;
      logic [2:0]  m;
      ev   = '0;
      emit = 1'b0;
      if (!halted) begin
         case (phase)
            Searching: begin
               m = oid_matched;
               if (b == CnOid[8*(4-m) +: 8]) m = m + 3'd1;
               else m = (b == dncs_pkg::OidFirst) ? 3'd1 : 3'd0;
               if (m == dncs_pkg::PatternLen) begin
                  m     = '0;
                  phase = AwaitTag;
               end
               oid_matched = m;
            end
            AwaitTag: begin
               if (b inside {dncs_pkg::TagUtf8, dncs_pkg::TagPrintable, dncs_pkg::TagIa5,
                             dncs_pkg::TagT61, dncs_pkg::TagBmp}) begin
                  string_tag = b;
                  phase      = AwaitLength;
               end else begin
                  // the rejected tag may open a new pattern
                  phase       = Searching;
                  oid_matched = (b == dncs_pkg::OidFirst) ? 3'd1 : 3'd0;
               end
            end
            AwaitLength: begin
               if (b == 8'h00 || b[7]) begin
                  phase       = Searching;
                  oid_matched = '0;
               end else begin
                  bytes_left  = b[6:0];
                  kept_chars  = '0;
                  bmp_pending = 1'b0;
                  bmp_high    = '0;
                  phase       = InValue;
               end
            end
            default: begin
               cap       = (names_count == 2'd0) ? first_cap : second_cap;
               got_char  = 1'b0;
               char_code = '0;
               if (string_tag == dncs_pkg::TagBmp) begin
                  if (bmp_pending) begin
                     char_code   = {bmp_high, b};
                     got_char    = 1'b1;
                     bmp_pending = 1'b0;
                  end else begin
                     bmp_high    = b;
                     bmp_pending = 1'b1;
                  end
               end else begin
                  char_code = (b >= dncs_pkg::PrintLow && b <= dncs_pkg::PrintHigh)
                              ? {8'h00, b} : {8'h00, dncs_pkg::Substitute};
                  got_char  = 1'b1;
               end
               // one slot stays reserved for the terminator
               if (got_char && cap != 9'd0 && kept_chars < cap - 9'd1) begin
                  ev.char_valid = 1'b1;
                  ev.char_value = char_code;
                  ev.which_name = names_count[0];
                  kept_chars    = kept_chars + 9'd1;
                  emit          = 1'b1;
               end
               bytes_left = bytes_left - 7'd1;
               if (bytes_left == 7'd0) begin
                  ev.which_name = names_count[0];
                  ev.name_end   = 1'b1;
                  emit          = 1'b1;
                  names_count   = names_count + 2'd1;
                  phase         = Searching;
                  oid_matched   = '0;
                  if (names_count >= 2'd2) halted = 1'b1;
               end
            end
         endcase
         if (is_last && phase == InValue) begin
            ev.name_cut   = 1'b1;
            ev.which_name = names_count[0];
            halted        = 1'b1;
         end
      end
      ev.scan_done   = is_last;
      ev.names_found = names_count;
      if (is_last) begin
         emit = 1'b1;
         restart_scan();
      end
   endtask

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, label, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      logic                      emit;
      dncs_pkg::rsp_payload_type ev;
      dncs_pkg::rsp_payload_type due;
      if (reset) begin
         first_cap  = 9'd128;
         second_cap = 9'd128;
         restart_scan();
         name_events_due.delete();
      end else begin
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr == first_cap_addr) first_cap = pwdata[8:0];
               else if (paddr == second_cap_addr) second_cap = pwdata[8:0];
            end else if (paddr == first_cap_addr) begin
               check_field("first capacity read", {23'd0, first_cap}, prdata);
            end else if (paddr == second_cap_addr) begin
               check_field("second capacity read", {23'd0, second_cap}, prdata);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            scan_byte(req_mon.data_byte, req_mon.last_byte, emit, ev);
            if (emit) name_events_due.push_back(ev);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (name_events_due.size() == 0) begin
               $display("%0t: unexpected result transfer, char %0h end %0b done %0b", $time,
                        rsp_mon.char_value, rsp_mon.name_end, rsp_mon.scan_done);
               errors++;
            end else begin
               due = name_events_due.pop_front();
               check_field("which_name", 32'(due.which_name), 32'(rsp_mon.which_name));
               check_field("char_valid", 32'(due.char_valid), 32'(rsp_mon.char_valid));
               check_field("char_value", 32'(due.char_value), 32'(rsp_mon.char_value));
               check_field("name_end", 32'(due.name_end), 32'(rsp_mon.name_end));
               check_field("name_cut", 32'(due.name_cut), 32'(rsp_mon.name_cut));
               check_field("scan_done", 32'(due.scan_done), 32'(rsp_mon.scan_done));
               check_field("names_found", 32'(due.names_found), 32'(rsp_mon.names_found));
            end
         end
      end
      pending_results = name_events_due.size();
   end

endmodule

>>> tb/der_common_name_scanner_unit_tb.sv
`timescale 1ns / 1ps

module der_common_name_scanner_unit_tb;

   localparam logic [2:0] FirstCapAddr  = 3'd0;
   localparam logic [2:0] SecondCapAddr = 3'd4;
   localparam int WatchdogLimit = 2000;
   localparam int HoldoffCycles = 80;
   localparam int DrainCycles   = 8;
   localparam int PhaseBytes    = 50;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   int          mismatch_count;
   int          pending_results;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   bit          holdoff_start = 1'b0;
   int          holdoff_left = 0;
   int          quiet_cycles = 0;
   int          phase_bytes;
   logic [7:0]  stream_bytes[$];

   dncs_req_if req_chan ();
   dncs_rsp_if rsp_chan ();

   der_common_name_scanner_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   der_common_name_scanner_unit_checker name_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .first_cap_addr  (FirstCapAddr),
      .second_cap_addr (SecondCapAddr),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   always #5 clock = ~clock;

   // result side: random stalls, or a long hold-off on request
   always @(negedge clock) begin
      if (holdoff_start) begin
         holdoff_left  = HoldoffCycles;
         holdoff_start = 1'b0;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (psel && penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= b;
      req_chan.last_byte <= is_last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_stream();
      if (stream_bytes.size() == 0) stream_bytes.push_back(8'($urandom_range(255)));
      foreach (stream_bytes[i]) send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
      phase_bytes += stream_bytes.size();
      stream_bytes.delete();
   endtask

   task automatic append_cn_attribute(input logic [7:0] tag, input logic [7:0] len_byte,
                                      input int value_len);
      stream_bytes.push_back(dncs_pkg::OidFirst);
      stream_bytes.push_back(8'h03);
      stream_bytes.push_back(8'h55);
      stream_bytes.push_back(8'h04);
      stream_bytes.push_back(8'h03);
      stream_bytes.push_back(tag);
      stream_bytes.push_back(len_byte);
      repeat (value_len) begin
         if ($urandom_range(1))
            stream_bytes.push_back(8'($urandom_range(dncs_pkg::PrintHigh, dncs_pkg::PrintLow)));
         else stream_bytes.push_back(8'($urandom_range(255)));
      end
   endtask

   task automatic build_random_stream();
      logic [7:0] tag;
      int         len;
      int         keep;
      repeat ($urandom_range(4, 1)) begin
         case ($urandom_range(9))
            0: begin
               // noise leaning on pattern bytes, so partial matches happen
               repeat ($urandom_range(6)) begin
                  case ($urandom_range(4))
                     0: stream_bytes.push_back(dncs_pkg::OidFirst);
                     1: stream_bytes.push_back(8'h03);
                     2: stream_bytes.push_back(8'h55);
                     3: stream_bytes.push_back(8'h04);
                     default: stream_bytes.push_back(8'($urandom_range(255)));
                  endcase
               end
            end
            1: begin
               tag = $urandom_range(1) ? dncs_pkg::OidFirst : 8'($urandom_range(255));
               append_cn_attribute(tag, 8'($urandom_range(1, 4)), 0);
            end
            2: begin
               append_cn_attribute(dncs_pkg::TagUtf8, $urandom_range(1) ? 8'h00
                                   : 8'($urandom_range(255, 128)), 0);
            end
            default: begin
               case ($urandom_range(4))
                  0: tag = dncs_pkg::TagUtf8;
                  1: tag = dncs_pkg::TagPrintable;
                  2: tag = dncs_pkg::TagIa5;
                  3: tag = dncs_pkg::TagT61;
                  default: tag = dncs_pkg::TagBmp;
               endcase
               len = ($urandom_range(59) == 0) ? $urandom_range(127, 100)
                                               : $urandom_range(12, 1);
               append_cn_attribute(tag, 8'(len), len);
            end
         endcase
      end
      // some streams end early: in the pattern, at the tag, length or value
      if ($urandom_range(4) == 0 && stream_bytes.size() > 1) begin
         keep = $urandom_range(stream_bytes.size(), 1);
         stream_bytes = stream_bytes[0:keep-1];
      end
   endtask

   task automatic csr_access(input logic wr, input logic [2:0] addr,
                             input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_scanner_idle();
      req_chan.valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic run_phase(input logic [8:0] cap0, input logic [8:0] cap1,
                            input int idle_pct, input int stall, input bit hold);
      wait_scanner_idle();
      csr_access(1'b1, FirstCapAddr, {23'd0, cap0});
      csr_access(1'b1, SecondCapAddr, {23'd0, cap1});
      csr_access(1'b0, FirstCapAddr, '0);
      csr_access(1'b0, SecondCapAddr, '0);
      psel    <= 1'b0;
      penable <= 1'b0;
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      if (hold) holdoff_start = 1'b1;
      phase_bytes = 0;
      while (phase_bytes < PhaseBytes) begin
         build_random_stream();
         send_stream();
      end
   endtask

   initial begin
      req_chan.valid     = 1'b0;
      req_chan.data_byte = '0;
      req_chan.last_byte = 1'b0;
      rsp_chan.ready     = 1'b0;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // rejected tag reopening the pattern, printable value of 00 and ff,
      // name ending on the last byte
      stream_bytes = '{8'h06, 8'h03, 8'h55, 8'h04, 8'h03, 8'h06, 8'h03, 8'h55, 8'h04,
                       8'h03, dncs_pkg::TagPrintable, 8'h02, 8'h00, 8'hFF};
      send_stream();
      // bmp with odd length, the unpaired byte yields no char
      stream_bytes = '{8'h06, 8'h03, 8'h55, 8'h04, 8'h03, dncs_pkg::TagBmp, 8'h03, 8'h12,
                       8'h34, 8'h56, 8'h00};
      send_stream();

      run_phase(9'd0, 9'd256, 0, 0, 1'b1);
      run_phase(9'd1, 9'd2, 46, 0, 1'b0);
      run_phase(9'd256, 9'd0, 0, 46, 1'b0);
      run_phase(9'd511, 9'd3, 31, 31, 1'b0);
      run_phase(9'($urandom_range(8)), 9'($urandom_range(511)), 0, 0, 1'b0);
      run_phase(9'd2, 9'd257, 46, 46, 1'b0);
      run_phase(9'($urandom_range(511)), 9'($urandom_range(8)), 31, 31, 1'b0);

      wait_scanner_idle();
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
